// ----- rtl/vqn_pkg.sv -----
// package for the nearest codeword search block
// fixed widths, commands and controller states; no dependencies
package vqn_pkg;
  localparam int CodeW = 16;
  localparam int LatW = 8;
  localparam int IdxW = 9;
  localparam int PosW = 6;
  localparam int DistW = 64;
  localparam logic [DistW-1:0] StartDist = 64'd6553600000;
  localparam logic [1:0] AddrScale = 2'd0;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_QUERY = 1'b1} cmd_t;
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  typedef struct packed {
    logic start;
    logic step;
  } cell_ctl_t;
endpackage

// ----- rtl/vqn_cell.sv -----
// one distance cell: squares one difference a cycle and accumulates
// uses vqn_pkg
module vqn_cell (
  input  logic                              clk,
  input  vqn_pkg::cell_ctl_t                ctl,
  input  logic signed [vqn_pkg::CodeW-1:0]  q,
  input  logic signed [vqn_pkg::CodeW-1:0]  c,
  output logic        [vqn_pkg::DistW-1:0]  acc
);
  logic signed [vqn_pkg::CodeW:0] d;
  logic [2*vqn_pkg::CodeW+1:0] sq;
  logic sq_v;
  logic [vqn_pkg::DistW-1:0] acc_next;

  always_comb begin
    acc_next = acc;
    if (ctl.start) acc_next = '0;
    else if (sq_v) acc_next = acc + vqn_pkg::DistW'(sq);
  end

  always_ff @(posedge clk) begin
    d <= {q[vqn_pkg::CodeW-1], q} - {c[vqn_pkg::CodeW-1], c};
    sq <= (2*vqn_pkg::CodeW+2)'(d * d);
    sq_v <= ctl.step & ~ctl.start;
    acc <= acc_next;
  end
endmodule

// ----- rtl/vq_nearest_codeword_search_top.sv -----
// top level of the nearest codeword search
// uses vqn_pkg and vqn_cell
// A search runs once per query beat flagged vector_last. The codebook is held in
// LANES bank memories; a row of LANES distance cells each sums one entry, walking
// the element positions one per cycle, and the minimum is taken from the cell
// chain, one cell per cycle. Each bank has one read port, so a search walks the
// groups of LANES entries in turn; no beat is accepted while it runs. Memory is
// undefined until written: no clearing pass.
module vq_nearest_codeword_search_top #(
  parameter int ENTRIES = 512,
  parameter int VECTOR_LENGTH = 64,
  parameter int LANES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic [8:0] entry_index,
  input  logic [5:0] element_position,
  input  logic signed [15:0] code_value,
  input  logic signed [7:0] latent_value,
  input  logic vector_last,
  output logic out_valid,
  input  logic out_ready,
  output logic [8:0] best_index
);
  localparam int GROUPS = (ENTRIES + LANES - 1) / LANES;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int KW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int KCW = $clog2(VECTOR_LENGTH + 1);
  localparam int EW = $clog2(ENTRIES);
  localparam int PHW = $clog2(VECTOR_LENGTH + LANES + 8);
  localparam int DRAIN = VECTOR_LENGTH + 3;
  localparam int AW = (GROUPS * VECTOR_LENGTH > 1) ? $clog2(GROUPS * VECTOR_LENGTH) : 1;

  // config register
  logic signed [15:0] latent_scale;
  assign pready = 1'b1;
  assign prdata = (paddr == vqn_pkg::AddrScale) ? {{16{latent_scale[15]}}, latent_scale}
                                                : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) latent_scale <= 16'sd256;
    else if (psel && penable && pwrite && paddr == vqn_pkg::AddrScale)
      latent_scale <= pwdata[15:0];
  end

  // query vector store
  logic signed [15:0] qmem [VECTOR_LENGTH];
  logic signed [23:0] prod;
  logic signed [15:0] sat;
  assign prod = latent_value * latent_scale;
  always_comb begin
    if (prod > 24'sd32767) sat = 16'sh7fff;
    else if (prod < -24'sd32768) sat = 16'sh8000;
    else sat = prod[15:0];
  end

  vqn_pkg::state_t state, state_next;
  logic acc_beat;
  assign in_ready = (state == vqn_pkg::ST_IDLE);
  assign acc_beat = in_valid & in_ready;

  // codebook banks: one per lane
  logic signed [15:0] cb_q [LANES];
  logic [GW-1:0] grp;
  logic [KCW-1:0] k;
  logic [KW-1:0] rd_k;
  assign rd_k = k[KW-1:0];
  logic [EW-1:0] ent;
  assign ent = EW'(entry_index);

  // bank word addresses: row of the entry within its bank, then position
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = AW'(32'(ent / LANES) * VECTOR_LENGTH + 32'(element_position));
  assign rd_addr = AW'(32'(grp) * VECTOR_LENGTH + 32'(rd_k));

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_bank
      logic signed [15:0] mem [GROUPS*VECTOR_LENGTH];
      logic wr;
      logic [EW-1:0] lane_sel;
      assign lane_sel = EW'(ent % LANES);
      assign wr = acc_beat && command == vqn_pkg::CMD_LOAD
                  && 32'(entry_index) < ENTRIES
                  && 32'(element_position) < VECTOR_LENGTH
                  && 32'(lane_sel) == g;
      always_ff @(posedge clk) begin
        if (wr) mem[wr_addr] <= code_value;
        cb_q[g] <= mem[rd_addr];
      end
    end
  endgenerate

  logic signed [15:0] q_rd;
  always_ff @(posedge clk) begin
    if (acc_beat && command == vqn_pkg::CMD_QUERY && 32'(element_position) < VECTOR_LENGTH)
      qmem[KW'(element_position)] <= sat;
    q_rd <= qmem[rd_k];
  end

  // sequencer: phase counts reads then drain and chain compare
  logic [PHW-1:0] ph, ph_next;
  logic [GW-1:0] grp_next;
  logic [KCW-1:0] k_next;
  logic rd_v, step_v, start_v;
  vqn_pkg::cell_ctl_t ctl;
  logic [LW:0] scan, scan_next;
  logic [vqn_pkg::DistW-1:0] best, best_next;
  logic [EW-1:0] bidx, bidx_next;
  logic [vqn_pkg::DistW-1:0] acc [LANES];
  logic [vqn_pkg::DistW-1:0] chain [LANES];
  logic ov_next;

  always_ff @(posedge clk) begin
    rd_v <= (state == vqn_pkg::ST_RUN) && 32'(k) < VECTOR_LENGTH && 32'(ph) != DRAIN;
    step_v <= rd_v;
    start_v <= (state == vqn_pkg::ST_RUN) && ph == '0;
  end
  assign ctl.start = start_v;
  assign ctl.step = step_v;

  generate
    for (g = 0; g < LANES; g++) begin : g_cell
      vqn_cell u_cell (.clk(clk), .ctl(ctl), .q(q_rd), .c(cb_q[g]), .acc(acc[g]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (32'(ph) == DRAIN + 1) chain[i] <= acc[i];
      else if (i + 1 < LANES) chain[i] <= chain[(i + 1) % LANES];
    end
  end

  always_comb begin
    state_next = state;
    ph_next = ph;
    k_next = k;
    grp_next = grp;
    scan_next = scan;
    best_next = best;
    bidx_next = bidx;
    ov_next = out_valid;
    if (out_valid && out_ready) ov_next = 1'b0;
    case (state)
      vqn_pkg::ST_IDLE: begin
        if (acc_beat && command == vqn_pkg::CMD_QUERY && vector_last) begin
          state_next = vqn_pkg::ST_RUN;
          ph_next = '0;
          k_next = '0;
          grp_next = '0;
          best_next = vqn_pkg::StartDist;
          bidx_next = '0;
        end
      end
      vqn_pkg::ST_RUN: begin
        ph_next = ph + 1'b1;
        if (32'(k) < VECTOR_LENGTH) k_next = k + 1'b1;
        if (32'(ph) == DRAIN + 1) scan_next = '0;
        if (32'(ph) > DRAIN + 1) begin
          if (32'(grp) * LANES + 32'(scan) < ENTRIES && chain[0] < best) begin
            best_next = chain[0];
            bidx_next = EW'(32'(grp) * LANES + 32'(scan));
          end
          scan_next = scan + 1'b1;
          if (32'(scan) == LANES - 1) begin
            ph_next = '0;
            k_next = '0;
            if (32'(grp) == GROUPS - 1) state_next = vqn_pkg::ST_DONE;
            else grp_next = grp + 1'b1;
          end
        end
      end
      vqn_pkg::ST_DONE: begin
        if (!out_valid) begin
          ov_next = 1'b1;
          state_next = vqn_pkg::ST_IDLE;
        end
      end
      default: state_next = vqn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vqn_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= ov_next;
    end
    ph <= ph_next;
    k <= k_next;
    grp <= grp_next;
    scan <= scan_next;
    best <= best_next;
    bidx <= bidx_next;
    if (state == vqn_pkg::ST_DONE && !out_valid) best_index <= 9'(bidx);
  end
endmodule
